// ===== sv/pcfe_pkg.sv =====
// Package: shared types, codes and reset values of the peak-count frequency estimator.
`timescale 1ns / 1ps

package pcfe_pkg;

    // Default sample width
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Field widths fixed by the register map
    localparam int STEP_BITS     = 16;
    localparam int WINDOW_BITS   = 16;
    localparam int SCALE_BITS    = 8;
    localparam int COUNT_BITS    = 16;
    localparam int PEAK_BITS     = COUNT_BITS + 1;
    localparam int ESTIMATE_BITS = 24;
    localparam int INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes
    localparam logic [INDEX_BITS-1:0] REG_SMALL_STEP    = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_LARGE_STEP    = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd2;
    localparam logic [INDEX_BITS-1:0] REG_SCALE         = 2'd3;

    // Register reset values
    localparam logic [STEP_BITS-1:0]   SMALL_STEP_RESET    = 16'd3;
    localparam logic [STEP_BITS-1:0]   LARGE_STEP_RESET    = 16'd20;
    localparam logic [WINDOW_BITS-1:0] WINDOW_LENGTH_RESET = 16'd2000;
    localparam logic [SCALE_BITS-1:0]  SCALE_RESET         = 8'd10;

    // Saturation limit of the peak counters
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Direction of the last move
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Square-wave detector state
    typedef enum logic [1:0] {
        WAVE_OTHER  = 2'd0,
        WAVE_MAYBE  = 2'd1,
        WAVE_SQUARE = 2'd2
    } wave_t;

    // Configuration register set
    typedef struct packed {
        logic [STEP_BITS-1:0]   small_step;
        logic [STEP_BITS-1:0]   large_step;
        logic [WINDOW_BITS-1:0] window_length;
        logic [SCALE_BITS-1:0]  scale;
    } cfg_t;

    // Window result handed from the tracker to the scaler
    typedef struct packed {
        logic                 valid;
        logic [PEAK_BITS-1:0] peaks;
    } peak_result_t;

endpackage

// ===== sv/pcfe_stream_if.sv =====
// Interfaces: sample and estimate stream channels with valid/ready handshake.
`timescale 1ns / 1ps

interface pcfe_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface pcfe_estimate_if #(
    parameter int ESTIMATE_BITS = 24
) ();
    logic                     valid;
    logic                     ready;
    logic [ESTIMATE_BITS-1:0] estimate;

    modport source (output valid, output estimate, input ready);
    modport sink (input valid, input estimate, output ready);
endinterface

// ===== sv/pcfe_tracker.sv =====
// Tracker: input register, hysteresis peak counting, square detection, window end.
`timescale 1ns / 1ps

module pcfe_tracker
    import pcfe_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output peak_result_t                  result,
    input  logic                          result_ready
);

    // Difference width: covers sample span and the unsigned thresholds
    localparam int DW = (SAMPLE_BITS + 2 > STEP_BITS + 2) ? SAMPLE_BITS + 2 : STEP_BITS + 2;

    // Input stage
    logic                          a_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    // Tracking state
    logic                          first_reg, first_next;
    dir_t                          dir_reg, dir_next;
    wave_t                         wave_reg, wave_next;
    logic signed [SAMPLE_BITS-1:0] ref_reg, ref_next;
    logic [COUNT_BITS-1:0]         max_reg, max_next;
    logic [COUNT_BITS-1:0]         min_reg, min_next;
    logic [WINDOW_BITS-1:0]        wpos_reg, wpos_next;

    // Result stage
    logic                          b_valid_reg, b_valid_next;
    logic [PEAK_BITS-1:0]          peaks_reg, peaks_next;

    logic                          b_ready;
    logic                          fire;
    logic signed [DW-1:0]          diff;
    logic signed [DW-1:0]          neg_diff;
    logic signed [DW-1:0]          amount;
    logic signed [DW-1:0]          small_ext;
    logic signed [DW-1:0]          large_ext;
    logic                          move_up;
    logic                          move_down;
    logic [WINDOW_BITS:0]          pos;
    logic [WINDOW_BITS:0]          limit;
    logic                          window_end;
    logic [COUNT_BITS-1:0]         peak_max;

    // Handshake chain
    assign b_ready  = !b_valid_reg || result_ready;
    assign in_ready = !a_valid_reg || b_ready;
    assign fire     = a_valid_reg && b_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg <= in_sample;
        end
    end

    // Move detection against the reference level
    assign diff      = DW'(sample_reg) - DW'(ref_reg);
    assign neg_diff  = -diff;
    assign small_ext = DW'({1'b0, cfg.small_step});
    assign large_ext = DW'({1'b0, cfg.large_step});
    assign move_up   = diff > small_ext;
    assign move_down = !move_up && (neg_diff > small_ext);
    assign amount    = move_up ? diff : neg_diff;

    // Window position; a zero length means a full 65536-sample window
    assign pos        = {1'b0, wpos_reg} + 1'b1;
    assign limit      = (cfg.window_length == '0) ? {1'b1, {WINDOW_BITS{1'b0}}}
                                                  : {1'b0, cfg.window_length};
    assign window_end = pos >= limit;

    // Next tracking state
    always_comb
    begin
        first_next = first_reg;
        dir_next   = dir_reg;
        wave_next  = wave_reg;
        ref_next   = ref_reg;
        max_next   = max_reg;
        min_next   = min_reg;
        wpos_next  = wpos_reg;

        if (first_reg)
        begin
            first_next = 1'b0;
            ref_next   = sample_reg;
        end
        else if (move_up || move_down)
        begin
            ref_next = sample_reg;
            dir_next = move_up ? DIR_UP : DIR_DOWN;
            // square detector advances on large moves only
            if (amount > large_ext)
            begin
                case (wave_reg)
                    WAVE_OTHER: wave_next = WAVE_MAYBE;
                    WAVE_MAYBE: wave_next = WAVE_SQUARE;
                    default:    wave_next = wave_reg;
                endcase
            end
            else
            begin
                wave_next = WAVE_OTHER;
            end
            // reversal counts a peak
            if (move_up && dir_reg == DIR_DOWN && min_reg != COUNT_MAX)
            begin
                min_next = min_reg + 1'b1;
            end
            if (move_down && dir_reg == DIR_UP && max_reg != COUNT_MAX)
            begin
                max_next = max_reg + 1'b1;
            end
        end

        if (!window_end)
        begin
            wpos_next = pos[WINDOW_BITS-1:0];
        end
    end

    // Window result and result-stage valid
    assign peak_max = (max_next > min_next) ? max_next : min_next;

    always_comb
    begin
        peaks_next = {1'b0, peak_max} + ((wave_next == WAVE_SQUARE) ? 1'b1 : 1'b0);
        if (fire && window_end)
        begin
            b_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg   <= 1'b1;
            dir_reg     <= DIR_NONE;
            wave_reg    <= WAVE_OTHER;
            ref_reg     <= '0;
            max_reg     <= '0;
            min_reg     <= '0;
            wpos_reg    <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            if (fire)
            begin
                ref_reg <= ref_next;
                if (window_end)
                begin
                    // clear tracking for the next window
                    first_reg <= 1'b1;
                    dir_reg   <= DIR_NONE;
                    wave_reg  <= WAVE_OTHER;
                    max_reg   <= '0;
                    min_reg   <= '0;
                    wpos_reg  <= '0;
                end
                else
                begin
                    first_reg <= first_next;
                    dir_reg   <= dir_next;
                    wave_reg  <= wave_next;
                    max_reg   <= max_next;
                    min_reg   <= min_next;
                    wpos_reg  <= wpos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && window_end)
        begin
            peaks_reg <= peaks_next;
        end
    end

    assign result.valid = b_valid_reg;
    assign result.peaks = peaks_reg;

    // A pending first sample means the window holds no tracking history
    a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg |-> (dir_reg == DIR_NONE && wave_reg == WAVE_OTHER
                       && max_reg == '0 && min_reg == '0))
        else $error("tracking state not clear while first sample pending");

    // A finished window restarts tracking
    a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && window_end) |=> (first_reg && wpos_reg == '0 && b_valid_reg))
        else $error("window end did not restart tracking");

    // A window result is never dropped while the scaler stalls
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !result_ready) |=> (b_valid_reg && $stable(peaks_reg)))
        else $error("window result lost under stall");

endmodule

// ===== sv/pcfe_scaler.sv =====
// Scaler: multiplies the window peak count by scale into the output register.
`timescale 1ns / 1ps

module pcfe_scaler
    import pcfe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SCALE_BITS-1:0] scale,
    input  peak_result_t         result,
    output logic                 result_ready,
    pcfe_estimate_if.source      estimates
);

    logic                                 c_valid_reg;
    logic [ESTIMATE_BITS-1:0]             estimate_reg;
    logic [SCALE_BITS+PEAK_BITS-1:0]      product;

    assign result_ready = !c_valid_reg || estimates.ready;
    assign product      = scale * result.peaks;

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (result_ready)
        begin
            c_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_ready && result.valid)
        begin
            estimate_reg <= product[ESTIMATE_BITS-1:0];
        end
    end

    assign estimates.valid    = c_valid_reg;
    assign estimates.estimate = estimate_reg;

endmodule

// ===== sv/peak_count_frequency_estimator.sv =====
// Top level: configuration registers and the tracker/scaler pipeline.
`timescale 1ns / 1ps

// Peak-count frequency estimator. Accepts one signed sample per clock cycle
// with no gaps of its own; the tracking state (reference level, direction,
// peak counters, square detector, window position) is updated in one
// combinational step, so that update loop sets the rate. A sample passes the
// input register, the tracker result register and the output multiplier
// register in that order; the estimate for a window is presented from the
// output register, one estimate per window_length samples (zero means
// 65536). Backpressure on the estimate channel only stalls the input once
// the result stages are full.
// Configuration writes take effect at the next edge and are meant for idle
// periods.
module peak_count_frequency_estimator
    import pcfe_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    pcfe_sample_if.sink              samples,
    pcfe_estimate_if.source          estimates
);

    cfg_t         cfg_reg;
    peak_result_t result;
    logic         result_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_step    <= SMALL_STEP_RESET;
            cfg_reg.large_step    <= LARGE_STEP_RESET;
            cfg_reg.window_length <= WINDOW_LENGTH_RESET;
            cfg_reg.scale         <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SMALL_STEP:    cfg_reg.small_step    <= cfg_data[STEP_BITS-1:0];
                REG_LARGE_STEP:    cfg_reg.large_step    <= cfg_data[STEP_BITS-1:0];
                REG_WINDOW_LENGTH: cfg_reg.window_length <= cfg_data[WINDOW_BITS-1:0];
                REG_SCALE:         cfg_reg.scale         <= cfg_data[SCALE_BITS-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Tracking and window result
    pcfe_tracker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (samples.valid),
        .in_ready     (samples.ready),
        .in_sample    (samples.sample),
        .result       (result),
        .result_ready (result_ready)
    );

    // Scaling and output register
    pcfe_scaler u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale        (cfg_reg.scale),
        .result       (result),
        .result_ready (result_ready),
        .estimates    (estimates)
    );

endmodule
